>>> sv/actr_pkg.sv
package actr_pkg;

  localparam int NUM_ROUNDS = 14;
  localparam int NUM_KEY_CELLS = 7;
  localparam logic [2:0] KEY_SETTLE = 3'd7;

  typedef logic [127:0] blk_t;
  typedef logic [255:0] kwin_t;
  typedef logic [15:0] bmask_t;
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KEY_WORD0 = 2'd0;
  localparam cfg_idx_t REG_KEY_WORD1 = 2'd1;
  localparam cfg_idx_t REG_KEY_WORD2 = 2'd2;
  localparam cfg_idx_t REG_KEY_WORD3 = 2'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [8] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> sv/actr_key_cell.sv
module actr_key_cell
  import actr_pkg::*;
#(
  parameter int STEP = 1
) (
  input  logic  clk,
  input  kwin_t win_in,
  output kwin_t win_out
);

  kwin_t win_r;
  kwin_t win_nxt;

  // derive the next eight schedule words from the previous window
  always_comb begin
    logic [31:0] p [8];
    logic [31:0] n [8];
    logic [31:0] t;
    for (int k = 0; k < 8; k++) begin
      p[k] = win_in[255-32*k -: 32];
    end
    t = sub_word({p[7][23:0], p[7][31:24]}) ^ {RCON[STEP], 24'h0};
    n[0] = p[0] ^ t;
    n[1] = p[1] ^ n[0];
    n[2] = p[2] ^ n[1];
    n[3] = p[3] ^ n[2];
    n[4] = p[4] ^ sub_word(n[3]);
    n[5] = p[5] ^ n[4];
    n[6] = p[6] ^ n[5];
    n[7] = p[7] ^ n[6];
    win_nxt = {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win_out = win_r;

endmodule

>>> sv/actr_round.sv
module actr_round
  import actr_pkg::*;
#(
  parameter bit LAST = 1'b0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   vld_in,
  input  blk_t   state_in,
  input  blk_t   data_in,
  input  bmask_t mask_in,
  input  blk_t   rkey,
  output logic   vld_out,
  output blk_t   state_out,
  output blk_t   data_out,
  output bmask_t mask_out
);

  logic   vld_r;
  blk_t   state_r;
  blk_t   data_r;
  bmask_t mask_r;
  blk_t   state_nxt;

  // one AES round: sub bytes, shift rows, mix columns (skipped in the last round), add round key
  always_comb begin
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) begin
      s[i] = SBOX[state_in[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = s[i + 4*((c+i) & 3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (LAST) begin
        m[4*c] = a0;
        m[4*c+1] = a1;
        m[4*c+2] = a2;
        m[4*c+3] = a3;
      end else begin
        m[4*c] = a0 ^ all ^ xtime(a0 ^ a1);
        m[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        m[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        m[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_nxt[127-8*i -: 8] = m[i] ^ rkey[127-8*i -: 8];
    end
  end

  // advance the stage valid bit with the whole chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  // hold payload while the chain is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
      data_r  <= data_in;
      mask_r  <= mask_in;
    end
  end

  assign vld_out   = vld_r;
  assign state_out = state_r;
  assign data_out  = data_r;
  assign mask_out  = mask_r;

endmodule

>>> sv/aes_ctr_stream_cipher.sv
// AES-256 counter-mode cipher; encryption and decryption are the same operation.
// Input channel (in_valid/in_ready): one 16-byte data beat per item. A beat with
// in_first_block set loads the 128-bit counter from in_nonce_hi/in_nonce_lo
// first; the counter then steps by one per beat, wrapping at 2^128. Bytes at or
// past in_valid_bytes (saturated at 16) come out as zero.
// Output channel (out_valid/out_ready): one result beat per input beat, in order.
// Key port: cfg_we writes cfg_data into key word cfg_index. The 256-bit key runs
// through a chain of seven key-schedule cells; after reset and after each key
// write in_ready stays low while that chain settles.
// Throughput: one beat per cycle while the chain is not stalled, set by the 14
// unrolled round cells, each a register stage. An accepted beat lands in the key
// add stage at the accepting edge, then crosses the 14 round cells and the
// output XOR/mask register on its way to out_valid.
// The whole chain moves as one; when out_ready is low and the output register
// is full, every stage holds and in_ready drops until the result is taken.
// Reset clears the key words and counter to zero and empties the chain.
module aes_ctr_stream_cipher
  import actr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_first_block,
  input  logic [63:0] in_nonce_hi,
  input  logic [63:0] in_nonce_lo,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  input  logic [4:0]  in_valid_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hi,
  output logic [63:0] out_lo,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_r [4];
  logic [2:0]  settle_r;
  blk_t        ctr_r;
  logic        out_valid_r;
  blk_t        out_r;

  kwin_t  kw [NUM_KEY_CELLS+1];
  logic   st_vld [NUM_ROUNDS+1];
  blk_t   st_state [NUM_ROUNDS+1];
  blk_t   st_data [NUM_ROUNDS+1];
  bmask_t st_mask [NUM_ROUNDS+1];

  logic   adv;
  logic   accept;
  blk_t   ctr_use;
  bmask_t mask_in;
  blk_t   out_nxt;
  logic [4:0] nbytes;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && (settle_r == 3'd0);
  assign accept   = in_valid && in_ready;

  // key words and settle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= 64'h0;
      end
      settle_r <= KEY_SETTLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD0: key_r[0] <= cfg_data;
        REG_KEY_WORD1: key_r[1] <= cfg_data;
        REG_KEY_WORD2: key_r[2] <= cfg_data;
        REG_KEY_WORD3: key_r[3] <= cfg_data;
        default: ;
      endcase
      settle_r <= KEY_SETTLE;
    end else if (settle_r != 3'd0) begin
      settle_r <= settle_r - 3'd1;
    end
  end

  // key schedule chain
  assign kw[0] = {key_r[0], key_r[1], key_r[2], key_r[3]};

  for (genvar j = 1; j <= NUM_KEY_CELLS; j++) begin : g_key
    actr_key_cell #(.STEP(j)) u_key (
      .clk     (clk),
      .win_in  (kw[j-1]),
      .win_out (kw[j])
    );
  end

  // pick counter, build byte mask
  assign ctr_use = in_first_block ? {in_nonce_hi, in_nonce_lo} : ctr_r;
  assign nbytes  = (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask_in[15-i] = (5'(i) < nbytes);
    end
  end

  // advance counter per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (accept) begin
      ctr_r <= ctr_use + 128'd1;
    end
  end

  // initial key add stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld[0] <= 1'b0;
    end else if (adv) begin
      st_vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_state[0] <= ctr_use ^ kw[0][255:128];
      st_data[0]  <= {in_data_hi, in_data_lo};
      st_mask[0]  <= mask_in;
    end
  end

  // round cells
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_rnd
    actr_round #(.LAST(r == NUM_ROUNDS)) u_rnd (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .vld_in    (st_vld[r-1]),
      .state_in  (st_state[r-1]),
      .data_in   (st_data[r-1]),
      .mask_in   (st_mask[r-1]),
      .rkey      ((r % 2 == 0) ? kw[r/2][255:128] : kw[r/2][127:0]),
      .vld_out   (st_vld[r]),
      .state_out (st_state[r]),
      .data_out  (st_data[r]),
      .mask_out  (st_mask[r])
    );
  end

  // combine keystream with data, drop invalid bytes
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      out_nxt[127-8*i -: 8] = (st_data[NUM_ROUNDS][127-8*i -: 8] ^
                               st_state[NUM_ROUNDS][127-8*i -: 8]) &
                              {8{st_mask[NUM_ROUNDS][15-i]}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_vld[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hi    = out_r[127:64];
  assign out_lo    = out_r[63:0];

endmodule
